@@ sv/sdp_pkg.sv @@
// shared types, constants and helpers for the sps dimension parser
package sdp_pkg;

   // defaults for the top level parameters
   localparam int GOLOMB_MAX_ZEROS_DEF   = 31;
   localparam int SCALING_FLAG_COUNT_DEF = 8;

   // result codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_SPS   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [4:0]  NAL_TYPE_SPS  = 5'd7;
   localparam logic [7:0]  PROFILE_HIGH  = 8'd100;
   localparam logic [7:0]  PROFILE_HI10  = 8'd110;
   localparam logic [7:0]  PROFILE_HI422 = 8'd122;
   localparam logic [7:0]  PROFILE_HI444 = 8'd144;
   localparam logic [31:0] ASPECT_EXTENDED = 32'd255;

   // syntax elements in stream order
   typedef enum logic [5:0] {
      S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_SEPPLANE,
      S_DEPTHL, S_DEPTHC, S_BYPASS, S_MATRIX, S_SCALING, S_FRAMENUM,
      S_POCTYPE, S_POCLSB, S_DELTAFLAG, S_OFFNONREF, S_OFFTB, S_CYCLE,
      S_REFOFF, S_NUMREF, S_GAPS, S_WIDTH, S_HEIGHT, S_FRAMEONLY, S_MBAFF,
      S_DIRECT, S_CROPFLAG, S_CL, S_CR, S_CT, S_CB, S_VUI, S_ARFLAG,
      S_ARIDC, S_SAR, S_OVFLAG, S_OVAPP, S_VSTFLAG, S_VSTBITS, S_COLOUR,
      S_CLOCFLAG, S_CLOCT, S_CLOCB, S_TIMFLAG, S_TICKS, S_SCALE, S_DONE
   } step_type;

   typedef enum logic [1:0] {
      PH_ZEROS, PH_SUFFIX, PH_FIXED
   } phase_type;

   typedef enum logic [2:0] {
      C_IDLE, C_SHIFT, C_CALC, C_DIV, C_LOAD
   } ctrl_type;

   // everything the walker has gathered for the final report
   typedef struct packed {
      logic [1:0]  status;
      logic        done;
      logic [15:0] width_mbs;
      logic [15:0] height_units;
      logic        frame_only;
      logic [1:0]  chroma;
      logic [16:0] crop_h;
      logic [16:0] crop_v;
      logic [31:0] tick_units;
      logic [31:0] tick_scale;
   } walk_type;

   // fixed field length of a step, zero for an exp-golomb code
   function automatic logic [5:0] step_bits(step_type s, logic [5:0] scal);
      logic [5:0] r;
      r = 6'd0;
      case (s)
         S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_ARIDC: r = 6'd8;
         S_SEPPLANE, S_BYPASS, S_MATRIX, S_DELTAFLAG, S_GAPS, S_FRAMEONLY,
         S_MBAFF, S_DIRECT, S_CROPFLAG, S_VUI, S_ARFLAG, S_OVFLAG, S_OVAPP,
         S_VSTFLAG, S_CLOCFLAG, S_TIMFLAG: r = 6'd1;
         S_SCALING: r = scal;
         S_VSTBITS: r = 6'd5;
         S_COLOUR: r = 6'd24;
         S_SAR, S_TICKS, S_SCALE: r = 6'd32;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

@@ sv/sdp_walker.sv @@
// bit-serial syntax walker over the sps fields
module sdp_walker import sdp_pkg::*; #(
   parameter int GOLOMB_MAX_ZEROS   = GOLOMB_MAX_ZEROS_DEF,
   parameter int SCALING_FLAG_COUNT = SCALING_FLAG_COUNT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     clear,
   input  logic     bit_valid,
   input  logic     bit_value,
   output walk_type walk
);

   step_type    step_ff, step_in;
   phase_type   phase_ff, phase_in;
   logic [5:0]  left_ff, left_in;
   logic [4:0]  zc_ff, zc_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  profile_ff, profile_in;
   logic [1:0]  chroma_ff, chroma_in;
   logic [7:0]  cycle_ff, cycle_in;
   logic [15:0] wmb_ff, wmb_in;
   logic [15:0] hu_ff, hu_in;
   logic        fo_ff, fo_in;
   logic [16:0] ch_ff, ch_in;
   logic [16:0] cv_ff, cv_in;
   logic [31:0] ticks_ff, ticks_in;
   logic [31:0] scale_ff, scale_in;
   logic [1:0]  status_ff, status_in;

   // next state of the walker for one incoming bit
   always_comb begin
      logic        fin;
      logic [31:0] v;
      logic [32:0] sum;
      logic        high;
      step_type    n;
      step_in   = step_ff;
      phase_in  = phase_ff;
      left_in   = left_ff;
      zc_in     = zc_ff;
      acc_in    = acc_ff;
      profile_in = profile_ff;
      chroma_in = chroma_ff;
      cycle_in  = cycle_ff;
      wmb_in    = wmb_ff;
      hu_in     = hu_ff;
      fo_in     = fo_ff;
      ch_in     = ch_ff;
      cv_in     = cv_ff;
      ticks_in  = ticks_ff;
      scale_in  = scale_ff;
      status_in = status_ff;
      fin  = 1'b0;
      v    = '0;
      sum  = '0;
      n    = step_ff;
      high = (profile_ff == PROFILE_HIGH) || (profile_ff == PROFILE_HI10) ||
             (profile_ff == PROFILE_HI422) || (profile_ff == PROFILE_HI444);
      if (clear) begin
         step_in    = S_HDR;
         phase_in   = PH_FIXED;
         left_in    = 6'd8;
         zc_in      = '0;
         acc_in     = '0;
         profile_in = '0;
         chroma_in  = 2'd1;
         cycle_in   = '0;
         wmb_in     = '0;
         hu_in      = '0;
         fo_in      = 1'b0;
         ch_in      = '0;
         cv_in      = '0;
         ticks_in   = '0;
         scale_in   = '0;
         status_in  = STATUS_TRUNCATED;
      end else if (bit_valid && step_ff != S_DONE) begin
         // bit collection
         case (phase_ff)
            PH_FIXED: begin
               acc_in  = {acc_ff[30:0], bit_value};
               left_in = left_ff - 6'd1;
               if (left_in == 6'd0) begin
                  fin = 1'b1;
                  v   = acc_in;
               end
            end
            PH_ZEROS: begin
               if (!bit_value) begin
                  if (zc_ff < 5'(GOLOMB_MAX_ZEROS)) zc_in = zc_ff + 5'd1;
               end else if (zc_ff == 5'd0) begin
                  fin = 1'b1;
               end else begin
                  phase_in = PH_SUFFIX;
                  left_in  = {1'b0, zc_ff};
                  acc_in   = '0;
               end
            end
            PH_SUFFIX: begin
               acc_in  = {acc_ff[30:0], bit_value};
               left_in = left_ff - 6'd1;
               if (left_in == 6'd0) begin
                  fin = 1'b1;
                  v   = ((32'd1 << zc_ff) - 32'd1) + acc_in;
               end
            end
            default: phase_in = PH_ZEROS;
         endcase
         // field complete: act on it and pick the next element
         if (fin) begin
            n = step_type'(step_ff + 6'd1);
            case (step_ff)
               S_HDR: begin
                  if (v[4:0] != NAL_TYPE_SPS) begin
                     status_in = STATUS_NOT_SPS;
                     n = S_DONE;
                  end
               end
               S_PROFILE: profile_in = v[7:0];
               S_SPSID: n = high ? S_CHROMA : S_FRAMENUM;
               S_CHROMA: begin
                  chroma_in = (v > 32'd3) ? 2'd3 : v[1:0];
                  n = (chroma_in == 2'd3) ? S_SEPPLANE : S_DEPTHL;
               end
               S_MATRIX: n = (v != 0) ? S_SCALING : S_FRAMENUM;
               S_SCALING: n = S_FRAMENUM;
               S_POCTYPE: begin
                  if (v == 32'd0) n = S_POCLSB;
                  else if (v == 32'd1) n = S_DELTAFLAG;
                  else n = S_NUMREF;
               end
               S_POCLSB: n = S_NUMREF;
               S_CYCLE: begin
                  cycle_in = (v > 32'd255) ? 8'd255 : v[7:0];
                  n = (cycle_in != 0) ? S_REFOFF : S_NUMREF;
               end
               S_REFOFF: begin
                  if (cycle_ff != 0) cycle_in = cycle_ff - 8'd1;
                  n = (cycle_in != 0) ? S_REFOFF : S_NUMREF;
               end
               S_WIDTH: wmb_in = (v >= 32'd65535) ? 16'hFFFF : v[15:0] + 16'd1;
               S_HEIGHT: hu_in = (v >= 32'd65535) ? 16'hFFFF : v[15:0] + 16'd1;
               S_FRAMEONLY: begin
                  fo_in = v[0];
                  n = v[0] ? S_DIRECT : S_MBAFF;
               end
               S_CROPFLAG: n = (v != 0) ? S_CL : S_VUI;
               S_CL, S_CR: begin
                  sum   = {16'd0, ch_ff} + {1'b0, v};
                  ch_in = (sum > 33'd131071) ? 17'h1FFFF : sum[16:0];
               end
               S_CT, S_CB: begin
                  sum   = {16'd0, cv_ff} + {1'b0, v};
                  cv_in = (sum > 33'd131071) ? 17'h1FFFF : sum[16:0];
               end
               S_VUI: n = (v != 0) ? S_ARFLAG : S_DONE;
               S_ARFLAG: n = (v != 0) ? S_ARIDC : S_OVFLAG;
               S_ARIDC: n = (v == ASPECT_EXTENDED) ? S_SAR : S_OVFLAG;
               S_SAR: n = S_OVFLAG;
               S_OVFLAG: n = (v != 0) ? S_OVAPP : S_VSTFLAG;
               S_VSTFLAG: n = (v != 0) ? S_VSTBITS : S_CLOCFLAG;
               S_VSTBITS: n = v[0] ? S_COLOUR : S_CLOCFLAG;
               S_CLOCFLAG: n = (v != 0) ? S_CLOCT : S_TIMFLAG;
               S_TIMFLAG: n = (v != 0) ? S_TICKS : S_DONE;
               S_TICKS: ticks_in = v;
               S_SCALE: begin
                  scale_in = v;
                  n = S_DONE;
               end
               default: n = step_type'(step_ff + 6'd1);
            endcase
            // open the next element
            step_in  = n;
            acc_in   = '0;
            zc_in    = '0;
            if (n == S_VUI) status_in = STATUS_OK;
            left_in  = step_bits(n, 6'(SCALING_FLAG_COUNT));
            phase_in = (left_in != 0) ? PH_FIXED : PH_ZEROS;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= S_HDR;
         phase_ff   <= PH_FIXED;
         left_ff    <= 6'd8;
         zc_ff      <= '0;
         acc_ff     <= '0;
         profile_ff <= '0;
         chroma_ff  <= 2'd1;
         cycle_ff   <= '0;
         wmb_ff     <= '0;
         hu_ff      <= '0;
         fo_ff      <= 1'b0;
         ch_ff      <= '0;
         cv_ff      <= '0;
         ticks_ff   <= '0;
         scale_ff   <= '0;
         status_ff  <= STATUS_TRUNCATED;
      end else begin
         step_ff    <= step_in;
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         zc_ff      <= zc_in;
         acc_ff     <= acc_in;
         profile_ff <= profile_in;
         chroma_ff  <= chroma_in;
         cycle_ff   <= cycle_in;
         wmb_ff     <= wmb_in;
         hu_ff      <= hu_in;
         fo_ff      <= fo_in;
         ch_ff      <= ch_in;
         cv_ff      <= cv_in;
         ticks_ff   <= ticks_in;
         scale_ff   <= scale_in;
         status_ff  <= status_in;
      end
   end

   // gathered values
   always_comb begin
      walk.status       = status_ff;
      walk.done         = (step_ff == S_DONE);
      walk.width_mbs    = wmb_ff;
      walk.height_units = hu_ff;
      walk.frame_only   = fo_ff;
      walk.chroma       = chroma_ff;
      walk.crop_h       = ch_ff;
      walk.crop_v       = cv_ff;
      walk.tick_units   = ticks_ff;
      walk.tick_scale   = scale_ff;
   end

endmodule

@@ sv/sdp_divider.sv @@
// restoring divider, one quotient bit per cycle, for the frame rate
module sdp_divider import sdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [30:0] quotient
);

   logic [32:0] rem_ff, rem_in;
   logic [31:0] dq_ff, dq_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   // one shift-subtract step
   always_comb begin
      logic [33:0] trial;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, dq_ff[31]};
      if (start) begin
         rem_in  = '0;
         dq_in   = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 33'(trial - {1'b0, dsr_ff});
            dq_in  = {dq_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[32:0];
            dq_in  = {dq_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff[30:0];

endmodule

@@ sv/h264_sps_dimension_parser.sv @@
// top level: byte intake, bit sequencer, result build and output register
//
//  channel | direction | ports                                  | handshake
//  req     | in        | req_data_byte, req_last_byte          | req_valid / req_stall
//  rsp     | out       | rsp_status, rsp_width, rsp_height,    | rsp_valid / rsp_stall
//          |           | rsp_fps                                |
//
// each byte is taken in and then shifted into the walker, one bit of the shift register per
// cycle; after the last byte of a unit the 32-step serial divider computes fps, then the
// result is built.
// after reset the block is ready at once; the walker restarts after every report.
// a stalled result waits in the output register while the next unit is taken in,
// only the next report waits for it.
module h264_sps_dimension_parser import sdp_pkg::*; #(
   parameter int GOLOMB_MAX_ZEROS   = GOLOMB_MAX_ZEROS_DEF,
   parameter int SCALING_FLAG_COUNT = SCALING_FLAG_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_width,
   output logic [15:0] rsp_height,
   output logic [30:0] rsp_fps
);

   ctrl_type    state_ff, state_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        vld_ff, vld_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [30:0] fps_ff, fps_in;

   logic        bit_valid;
   logic        clear;
   logic        div_start;
   logic        div_done;
   logic [30:0] div_q;
   walk_type    walk;

   sdp_walker #(
      .GOLOMB_MAX_ZEROS  (GOLOMB_MAX_ZEROS),
      .SCALING_FLAG_COUNT(SCALING_FLAG_COUNT)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear),
      .bit_valid(bit_valid),
      .bit_value(byte_ff[7]),
      .walk     (walk)
   );

   sdp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(walk.tick_scale),
      .divisor ({walk.tick_units, 1'b0}),
      .done    (div_done),
      .quotient(div_q)
   );

   logic out_free;
   assign out_free = !vld_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_IDLE:  if (req_valid) state_in = C_SHIFT;
         C_SHIFT: if (cnt_ff == 3'd7) state_in = last_ff ? C_CALC : C_IDLE;
         C_CALC:  state_in = C_DIV;
         C_DIV:   if (div_done) state_in = C_LOAD;
         C_LOAD:  if (out_free) state_in = C_IDLE;
         default: state_in = C_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = (state_ff != C_IDLE);
      bit_valid = (state_ff == C_SHIFT);
      div_start = (state_ff == C_CALC);
      clear     = (state_ff == C_LOAD) && out_free;
   end

   // byte shift register
   always_comb begin
      byte_in = byte_ff;
      last_in = last_ff;
      cnt_in  = cnt_ff;
      if (state_ff == C_IDLE && req_valid) begin
         byte_in = req_data_byte;
         last_in = req_last_byte;
         cnt_in  = '0;
      end else if (state_ff == C_SHIFT) begin
         byte_in = {byte_ff[6:0], 1'b0};
         cnt_in  = cnt_ff + 3'd1;
      end
   end

   // cropped dimensions and the output register
   always_comb begin
      logic [20:0] wpos, wneg, hpos, hneg, wd, hd;
      wpos = {1'b0, walk.width_mbs, 4'd0};
      wneg = (walk.chroma == 2'd1 || walk.chroma == 2'd2) ?
             {3'd0, walk.crop_h, 1'b0} : {4'd0, walk.crop_h};
      hpos = walk.frame_only ? {1'b0, walk.height_units, 4'd0} :
                               {walk.height_units, 5'd0};
      case ({walk.chroma == 2'd1, walk.frame_only})
         2'b11:   hneg = {3'd0, walk.crop_v, 1'b0};
         2'b10:   hneg = {2'd0, walk.crop_v, 2'b0};
         2'b01:   hneg = {4'd0, walk.crop_v};
         default: hneg = {3'd0, walk.crop_v, 1'b0};
      endcase
      wd = wpos - wneg;
      hd = hpos - hneg;
      vld_in    = vld_ff;
      status_in = status_ff;
      width_in  = width_ff;
      height_in = height_ff;
      fps_in    = fps_ff;
      if (vld_ff && !rsp_stall) vld_in = 1'b0;
      if (state_ff == C_LOAD && out_free) begin
         vld_in    = 1'b1;
         status_in = walk.status;
         width_in  = '0;
         height_in = '0;
         fps_in    = '0;
         if (walk.status == STATUS_OK) begin
            if (wneg > wpos) width_in = '0;
            else if (wd > 21'd65535) width_in = 16'hFFFF;
            else width_in = wd[15:0];
            if (hneg > hpos) height_in = '0;
            else if (hd > 21'd65535) height_in = 16'hFFFF;
            else height_in = hd[15:0];
            if (walk.done && walk.tick_units != 0) fps_in = div_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         vld_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         cnt_ff   <= cnt_in;
      end
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      fps_ff    <= fps_in;
   end

   assign rsp_valid  = vld_ff;
   assign rsp_status = status_ff;
   assign rsp_width  = width_ff;
   assign rsp_height = height_ff;
   assign rsp_fps    = fps_ff;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for the sps dimension parser: unit builder, bit-level predictor and result checks
module tb_top import sdp_pkg::*;;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_width;
   logic [15:0] rsp_height;
   logic [30:0] rsp_fps;

   // one report of the parser
   typedef struct {
      logic [1:0]  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [30:0] fps;
   } report_type;

   // one byte transaction with an optional hand-written expectation
   typedef struct {
      logic [7:0] data;
      bit         last;
      bit         typed;
      report_type want;
   } byte_item_type;

   // knobs for building one sps unit
   typedef struct {
      logic [7:0]      nal;
      logic [7:0]      prof;
      longint unsigned chroma, poc, cyc, wm1, hm1, cl, cr, ct, cb, ticks, scale;
      bit              fo, crop, vui, tim, longz, typed;
      int              cut, noise;
      report_type      want;
   } unit_type;

   localparam int DIR_ROWS   = 17;
   localparam int BYTE_COUNT = 1850;

   always #4 clock = ~clock;

   h264_sps_dimension_parser i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_width     (rsp_width),
      .rsp_height    (rsp_height),
      .rsp_fps       (rsp_fps)
   );

   // sps walker state
   step_type        w_step;
   int              w_left, w_zeros;
   phase_type       w_phase;
   logic [31:0]     w_acc;
   logic [7:0]      w_profile;
   int              w_chroma, w_poc, w_refs;
   longint unsigned w_width_mbs, w_height_units, w_crop_h, w_crop_v;
   bit              w_frame_only;
   logic [31:0]     w_ticks, w_scale;
   logic [1:0]      w_status;

   report_type    expected_reports[$];
   bit            unit_bits[$];
   byte_item_type unit_bytes[$];
   byte_item_type cur_item;

   int  error_count = 0;
   int  bytes_sent = 0;
   int  units_sent = 0;
   int  reports_seen = 0;
   bit  quiet = 1'b0;
   bit  hold_request = 1'b0;

   // bits of the fixed-width field of a syntax step, zero for exp-golomb
   function automatic int field_len(step_type s);
      case (s)
         S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_ARIDC: return 8;
         S_SEPPLANE, S_BYPASS, S_MATRIX, S_DELTAFLAG, S_GAPS, S_FRAMEONLY, S_MBAFF,
         S_DIRECT, S_CROPFLAG, S_VUI, S_ARFLAG, S_OVFLAG, S_OVAPP, S_VSTFLAG,
         S_CLOCFLAG, S_TIMFLAG: return 1;
         S_SCALING: return SCALING_FLAG_COUNT_DEF;
         S_VSTBITS: return 5;
         S_COLOUR: return 24;
         S_SAR, S_TICKS, S_SCALE: return 32;
         default: return 0;
      endcase
   endfunction

   function automatic longint unsigned sat_crop(longint unsigned a, longint unsigned b);
      longint unsigned t;
      t = a + b;
      return (t > 131071) ? 131071 : t;
   endfunction

   function automatic longint unsigned sat_count(longint unsigned v);
      return (v + 1 > 65535) ? 65535 : v + 1;
   endfunction

   function void enter_step(step_type s);
      w_step  = s;
      w_acc   = '0;
      w_zeros = 0;
      if (s == S_VUI) w_status = STATUS_OK;
      w_left  = field_len(s);
      w_phase = (w_left != 0) ? PH_FIXED : PH_ZEROS;
   endfunction

   function void walker_clear();
      w_profile      = '0;
      w_chroma       = 1;
      w_poc          = 0;
      w_refs         = 0;
      w_width_mbs    = 0;
      w_height_units = 0;
      w_frame_only   = 1'b0;
      w_crop_h       = 0;
      w_crop_v       = 0;
      w_ticks        = '0;
      w_scale        = '0;
      w_status       = STATUS_TRUNCATED;
      enter_step(S_HDR);
   endfunction

   // a complete field: record what matters and pick the next syntax step
   function void close_field(longint unsigned v);
      step_type n;
      bit       hi;
      hi = (w_profile == PROFILE_HIGH) || (w_profile == PROFILE_HI10) ||
           (w_profile == PROFILE_HI422) || (w_profile == PROFILE_HI444);
      n = step_type'(w_step + 1);
      case (w_step)
         S_HDR: if (v[4:0] != NAL_TYPE_SPS) begin
            w_status = STATUS_NOT_SPS;
            n = S_DONE;
         end
         S_PROFILE: w_profile = v[7:0];
         S_SPSID: n = hi ? S_CHROMA : S_FRAMENUM;
         S_CHROMA: begin
            w_chroma = (v > 3) ? 3 : int'(v);
            n = (w_chroma == 3) ? S_SEPPLANE : S_DEPTHL;
         end
         S_MATRIX: n = (v != 0) ? S_SCALING : S_FRAMENUM;
         S_SCALING: n = S_FRAMENUM;
         S_POCTYPE: begin
            w_poc = (v > 3) ? 3 : int'(v);
            n = (w_poc == 0) ? S_POCLSB : ((w_poc == 1) ? S_DELTAFLAG : S_NUMREF);
         end
         S_POCLSB: n = S_NUMREF;
         S_CYCLE: begin
            w_refs = (v > 255) ? 255 : int'(v);
            n = (w_refs != 0) ? S_REFOFF : S_NUMREF;
         end
         S_REFOFF: begin
            if (w_refs != 0) w_refs--;
            n = (w_refs != 0) ? S_REFOFF : S_NUMREF;
         end
         S_WIDTH: w_width_mbs = sat_count(v);
         S_HEIGHT: w_height_units = sat_count(v);
         S_FRAMEONLY: begin
            w_frame_only = v[0];
            n = w_frame_only ? S_DIRECT : S_MBAFF;
         end
         S_CROPFLAG: n = (v != 0) ? S_CL : S_VUI;
         S_CL, S_CR: w_crop_h = sat_crop(w_crop_h, v);
         S_CT, S_CB: w_crop_v = sat_crop(w_crop_v, v);
         S_VUI: n = (v != 0) ? S_ARFLAG : S_DONE;
         S_ARFLAG: n = (v != 0) ? S_ARIDC : S_OVFLAG;
         S_ARIDC: n = (v == ASPECT_EXTENDED) ? S_SAR : S_OVFLAG;
         S_SAR: n = S_OVFLAG;
         S_OVFLAG: n = (v != 0) ? S_OVAPP : S_VSTFLAG;
         S_VSTFLAG: n = (v != 0) ? S_VSTBITS : S_CLOCFLAG;
         S_VSTBITS: n = v[0] ? S_COLOUR : S_CLOCFLAG;
         S_CLOCFLAG: n = (v != 0) ? S_CLOCT : S_TIMFLAG;
         S_TIMFLAG: n = (v != 0) ? S_TICKS : S_DONE;
         S_TICKS: w_ticks = v[31:0];
         S_SCALE: begin
            w_scale = v[31:0];
            n = S_DONE;
         end
         default: ;
      endcase
      enter_step(n);
   endfunction

   function void walk_bit(bit b);
      if (w_step == S_DONE) return;
      if (w_phase == PH_FIXED) begin
         w_acc = {w_acc[30:0], b};
         if (w_left != 0) w_left--;
         if (w_left == 0) close_field(w_acc);
      end else if (w_phase == PH_ZEROS) begin
         if (!b) begin
            if (w_zeros < GOLOMB_MAX_ZEROS_DEF) w_zeros++;
         end else if (w_zeros == 0) begin
            close_field(0);
         end else begin
            w_phase = PH_SUFFIX;
            w_left  = w_zeros;
            w_acc   = '0;
         end
      end else begin
         w_acc = {w_acc[30:0], b};
         if (w_left != 0) w_left--;
         if (w_left == 0)
            close_field(((64'd1 << (w_zeros & 31)) - 1) + w_acc);
      end
   endfunction

   // feeds one byte, returns 1 with the report when the unit ends
   function bit parse_byte(logic [7:0] d, bit last, output report_type r);
      longint fy, ux, uy, w, h;
      for (int i = 7; i >= 0; i--) walk_bit(d[i]);
      if (!last) return 1'b0;
      r.status = w_status;
      r.width  = '0;
      r.height = '0;
      r.fps    = '0;
      if (w_status == STATUS_OK) begin
         fy = 2 - w_frame_only;
         ux = (w_chroma == 1 || w_chroma == 2) ? 2 : 1;
         uy = (w_chroma == 1) ? 2 * fy : fy;
         w = longint'(w_width_mbs) * 16 - ux * longint'(w_crop_h);
         h = fy * longint'(w_height_units) * 16 - uy * longint'(w_crop_v);
         r.width  = (w < 0) ? 16'd0 : ((w > 65535) ? 16'hFFFF : w[15:0]);
         r.height = (h < 0) ? 16'd0 : ((h > 65535) ? 16'hFFFF : h[15:0]);
         if (w_step == S_DONE && w_ticks != 0)
            r.fps = 31'(64'(w_scale) / (64'd2 * 64'(w_ticks)));
      end
      walker_clear();
      return 1'b1;
   endfunction

   task put_bits(longint unsigned v, int n);
      for (int i = n - 1; i >= 0; i--) unit_bits.push_back(v[i]);
   endtask

   task put_ue(longint unsigned v);
      longint unsigned x;
      int              len;
      x = v + 1;
      len = 0;
      while ((x >> len) != 0) len++;
      put_bits(0, len - 1);
      put_bits(x, len);
   endtask

   // turns knobs into the byte transactions of one unit
   task build_unit(unit_type u);
      bit            ar, ov, vst, cloc, mtx;
      logic [7:0]    idc;
      logic [4:0]    vbits;
      int            keep, loops;
      byte_item_type it;
      unit_bits.delete();
      unit_bytes.delete();
      it.typed = u.typed;
      it.want  = u.want;
      if (u.noise > 0) begin
         for (int i = 0; i < u.noise; i++) begin
            it.data = 8'($urandom);
            it.last = (i == u.noise - 1);
            unit_bytes.push_back(it);
         end
         return;
      end
      put_bits(u.nal, 8);
      put_bits(u.prof, 8);
      put_bits($urandom, 8);
      put_bits($urandom, 8);
      if (u.longz) begin
         put_bits(0, 40);
         put_bits(1, 1);
         put_bits($urandom, 31);
      end else put_ue($urandom_range(0, 31));
      if (u.prof == PROFILE_HIGH || u.prof == PROFILE_HI10 ||
          u.prof == PROFILE_HI422 || u.prof == PROFILE_HI444) begin
         put_ue(u.chroma);
         if (u.chroma >= 3) put_bits($urandom, 1);
         put_ue($urandom_range(0, 6));
         put_ue($urandom_range(0, 6));
         put_bits($urandom, 1);
         mtx = 1'($urandom);
         put_bits(mtx, 1);
         if (mtx) put_bits($urandom, 8);
      end
      put_ue($urandom_range(0, 12));
      put_ue(u.poc);
      if (u.poc == 0) put_ue($urandom_range(0, 12));
      else if (u.poc == 1) begin
         put_bits($urandom, 1);
         put_ue($urandom_range(0, 1000));
         put_ue($urandom_range(0, 1000));
         put_ue(u.cyc);
         loops = (u.cyc > 255) ? 255 : int'(u.cyc);
         repeat (loops) put_ue($urandom_range(0, 300));
      end
      put_ue($urandom_range(0, 16));
      put_bits($urandom, 1);
      put_ue(u.wm1);
      put_ue(u.hm1);
      put_bits(u.fo, 1);
      if (!u.fo) put_bits($urandom, 1);
      put_bits($urandom, 1);
      put_bits(u.crop, 1);
      if (u.crop) begin
         put_ue(u.cl);
         put_ue(u.cr);
         put_ue(u.ct);
         put_ue(u.cb);
      end
      put_bits(u.vui, 1);
      if (u.vui) begin
         ar = 1'($urandom);
         put_bits(ar, 1);
         if (ar) begin
            idc = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom);
            put_bits(idc, 8);
            if (idc == 8'd255) put_bits($urandom, 32);
         end
         ov = 1'($urandom);
         put_bits(ov, 1);
         if (ov) put_bits($urandom, 1);
         vst = 1'($urandom);
         put_bits(vst, 1);
         if (vst) begin
            vbits = 5'($urandom);
            put_bits(vbits, 5);
            if (vbits[0]) put_bits($urandom, 24);
         end
         cloc = 1'($urandom);
         put_bits(cloc, 1);
         if (cloc) begin
            put_ue($urandom_range(0, 5));
            put_ue($urandom_range(0, 5));
         end
         put_bits(u.tim, 1);
         if (u.tim) begin
            put_bits(u.ticks, 32);
            put_bits(u.scale, 32);
         end
      end
      // trailing bits and bytes that the walker ignores
      while (unit_bits.size() % 8 != 0) unit_bits.push_back(1'($urandom));
      repeat ($urandom_range(0, 2)) put_bits($urandom, 8);
      keep = unit_bits.size() / 8 - u.cut;
      if (keep < 1) keep = 1;
      for (int i = 0; i < keep; i++) begin
         for (int j = 0; j < 8; j++) it.data[7 - j] = unit_bits[8 * i + j];
         it.last = (i == keep - 1);
         unit_bytes.push_back(it);
      end
   endtask

   function automatic unit_type plain_unit();
      unit_type u;
      u.nal = 8'h67;   u.prof = 8'd66;
      u.chroma = 1;    u.poc = 2;      u.cyc = 0;
      u.wm1 = 0;       u.hm1 = 0;
      u.cl = 0;        u.cr = 0;       u.ct = 0;    u.cb = 0;
      u.ticks = 0;     u.scale = 0;
      u.fo = 1'b1;     u.crop = 1'b0;  u.vui = 1'b0; u.tim = 1'b0;
      u.longz = 1'b0;  u.typed = 1'b0;
      u.cut = 0;       u.noise = 0;
      u.want = '{STATUS_OK, 16'd0, 16'd0, 31'd0};
      return u;
   endfunction

   // directed units: extremes, error codes and the special cases
   function automatic unit_type directed_row(int k);
      unit_type u;
      u = plain_unit();
      case (k)
         // header byte only
         0: begin u.cut = 1000; u.typed = 1'b1;
            u.want = '{STATUS_TRUNCATED, 16'd0, 16'd0, 31'd0}; end
         // wrong nal type
         1: begin u.nal = 8'h68; u.typed = 1'b1;
            u.want = '{STATUS_NOT_SPS, 16'd0, 16'd0, 31'd0}; end
         2: begin u.nal = 8'h00; u.typed = 1'b1;
            u.want = '{STATUS_NOT_SPS, 16'd0, 16'd0, 31'd0}; end
         3: begin u.typed = 1'b1;
            u.want = '{STATUS_OK, 16'd16, 16'd16, 31'd0}; end
         // saturated dimensions
         4: begin u.wm1 = 70000; u.hm1 = 4095; u.fo = 1'b0; u.typed = 1'b1;
            u.want = '{STATUS_OK, 16'hFFFF, 16'hFFFF, 31'd0}; end
         // cropped below zero
         5: begin u.crop = 1'b1; u.cl = 1000; u.typed = 1'b1;
            u.want = '{STATUS_OK, 16'd0, 16'd16, 31'd0}; end
         6: begin u.vui = 1'b1; u.tim = 1'b1; u.ticks = 1001; u.scale = 60000;
            u.typed = 1'b1;
            u.want = '{STATUS_OK, 16'd16, 16'd16, 31'd29}; end
         // zero tick count
         7: begin u.vui = 1'b1; u.tim = 1'b1; u.ticks = 0; u.scale = 50; u.typed = 1'b1;
            u.want = '{STATUS_OK, 16'd16, 16'd16, 31'd0}; end
         8: begin u.prof = PROFILE_HIGH; u.chroma = 0; u.poc = 1; u.cyc = 3; u.wm1 = 119;
            u.hm1 = 67; u.crop = 1'b1; u.cb = 4; end
         // oversized chroma format and poc type
         9: begin u.prof = PROFILE_HI444; u.chroma = 7; u.poc = 5; u.wm1 = 10; u.hm1 = 5;
            u.fo = 1'b0; u.crop = 1'b1; u.cr = 3; u.ct = 2; end
         10: begin u.prof = PROFILE_HI422; u.chroma = 2; u.poc = 0; u.crop = 1'b1;
            u.cl = 2; u.cb = 1; u.wm1 = 20; u.hm1 = 20; end
         // reference cycle beyond its cap
         11: begin u.poc = 1; u.cyc = 300; end
         // long golomb prefix
         12: begin u.longz = 1'b1; u.wm1 = 3; end
         // unit ends inside the timing fields
         13: begin u.vui = 1'b1; u.tim = 1'b1; u.ticks = 1; u.scale = 32'hFFFFFFFF;
            u.cut = 5; end
         14: begin u.wm1 = 32'h7FFFFFFE; u.hm1 = 32'h7FFFFFFE; u.vui = 1'b1; u.tim = 1'b1;
            u.ticks = 1; u.scale = 32'hFFFFFFFF; end
         // crop sums at their cap
         15: begin u.crop = 1'b1; u.cl = 100000; u.cr = 100000; u.ct = 90000; u.cb = 90000;
            u.wm1 = 70000; u.hm1 = 70000; end
         16: begin u.nal = 8'hFF; u.cut = 1000; u.typed = 1'b1;
            u.want = '{STATUS_NOT_SPS, 16'd0, 16'd0, 31'd0}; end
         default: ;
      endcase
      return u;
   endfunction

   function automatic longint unsigned pick_ue(int big_odds, int lo_max, int big_lo, int big_hi);
      if ($urandom_range(0, big_odds - 1) == 0) return $urandom_range(big_lo, big_hi);
      return $urandom_range(0, lo_max);
   endfunction

   // mostly well-formed units with random content, some noise and cut units
   function automatic unit_type random_unit();
      unit_type u;
      u = plain_unit();
      if ($urandom_range(0, 19) == 0) u.noise = $urandom_range(1, 6);
      u.nal = {3'($urandom), 5'd7};
      if ($urandom_range(0, 11) == 0) begin
         u.nal = 8'($urandom);
         if (u.nal[4:0] == NAL_TYPE_SPS) u.nal[3] = 1'b1;
      end
      case ($urandom_range(0, 7))
         0: u.prof = 8'd66;
         1: u.prof = 8'd77;
         2: u.prof = 8'd88;
         3: u.prof = PROFILE_HIGH;
         4: u.prof = PROFILE_HI10;
         5: u.prof = PROFILE_HI422;
         6: u.prof = PROFILE_HI444;
         default: u.prof = 8'($urandom);
      endcase
      u.chroma = pick_ue(5, 3, 4, 100);
      u.poc    = $urandom_range(0, 5);
      u.cyc    = pick_ue(40, 6, 256, 400);
      u.wm1    = pick_ue(20, 120, 60000, 100000);
      u.hm1    = pick_ue(20, 120, 60000, 100000);
      u.fo     = 1'($urandom);
      u.crop   = 1'($urandom);
      u.cl     = pick_ue(20, 20, 0, 70000);
      u.cr     = pick_ue(20, 20, 0, 70000);
      u.ct     = pick_ue(20, 20, 0, 70000);
      u.cb     = pick_ue(20, 20, 0, 70000);
      u.vui    = ($urandom_range(0, 9) < 6);
      u.tim    = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 7))
         0: u.ticks = 0;
         1, 2: u.ticks = $urandom_range(1, 3000);
         default: u.ticks = $urandom;
      endcase
      u.scale  = $urandom;
      u.cut    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 0;
      u.longz  = ($urandom_range(0, 29) == 0);
      return u;
   endfunction

   // drives the built unit byte by byte
   task send_unit();
      foreach (unit_bytes[i]) begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= unit_bytes[i].data;
         req_last_byte <= unit_bytes[i].last;
         cur_item      <= unit_bytes[i];
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
      units_sent++;
   endtask

   // predict on every accepted byte
   always @(posedge clock) begin
      report_type r;
      if (!reset && req_valid && !req_stall) begin
         if (parse_byte(req_data_byte, req_last_byte, r))
            expected_reports.push_back(cur_item.typed ? cur_item.want : r);
      end
   end

   function void check_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
         error_count++;
      end
   endfunction

   // compare every accepted report with the oldest expectation
   always @(posedge clock) begin
      report_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none actual status %0d",
                     $time, rsp_status);
            error_count++;
         end else begin
            e = expected_reports.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("width", e.width, rsp_width);
            check_field("height", e.height, rsp_height);
            check_field("fps", e.fps, rsp_fps);
         end
      end
   end

   // result side stalls: random bursts plus one long hold
   initial begin
      int burst;
      int hold_left;
      burst = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(1, 12) - 1;
         end else rsp_stall <= 1'b0;
      end
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // reset, directed units, random units, drain
   initial begin
      unit_type u;
      walker_clear();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int k = 0; k < DIR_ROWS; k++) begin
         u = directed_row(k);
         build_unit(u);
         send_unit();
      end
      while (bytes_sent < BYTE_COUNT) begin
         if (bytes_sent > BYTE_COUNT - 300) quiet = 1'b1;
         if (units_sent == 30) hold_request = 1'b1;
         if (units_sent == 50) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (expected_reports.size() != 0) @(posedge clock);
         end
         u = random_unit();
         build_unit(u);
         send_unit();
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("sent %0d units in %0d bytes, %0d reports checked", units_sent, bytes_sent,
               reports_seen);
      $display("mix of sps profiles, poc types, crops, vui timing, cut and foreign units");
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
sv/sdp_pkg.sv
sv/sdp_walker.sv
sv/sdp_divider.sv
sv/h264_sps_dimension_parser.sv
sim/tb_top.sv
